@@ sv/tcce_pkg.sv @@
// Shared constants and command codes for the text console cursor engine.
package tcce_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int POS_W  = 11;
  localparam int IDX_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;
  localparam logic [2:0]        TAB_STOP   = 3'd4;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

endpackage

@@ sv/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine: cursor control and screen store.
//
//  channel   direction  handshake               fields
//  command   in         start & !busy           cmd_i, char_code_i, cell_index_i
//  result    out        done_o (one cycle)      cursor_pos_o, cell_char_o, cell_attr_o
//  config    in         cfg_we_i                cfg_wdata_i (text attribute)
//
// Put without scroll and unused commands: result in the cycle after the command beat.
// Read in range: the cell is registered in the RAM read port, then in the result registers;
// a read out of range answers in the cycle after the beat.
// Put that scrolls: the screen is a ring of rows, so a scroll blanks one row and moves
// the top-row base. Clear: a sweep over all ROWS * COLUMNS cells.
// After reset a clearing pass over all ROWS * COLUMNS cells runs with busy high.
// The receiver cannot stall: each result beat lasts exactly one cycle.
module text_console_cursor_engine #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [tcce_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcce_pkg::IDX_W-1:0]    cell_index_i,
  output logic                          done_o,
  output logic [tcce_pkg::POS_W-1:0]    cursor_pos_o,
  output logic [tcce_pkg::CHAR_W-1:0]   cell_char_o,
  output logic [tcce_pkg::ATTR_W-1:0]   cell_attr_o,
  input  logic                          cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0]   cfg_wdata_i
);

  import tcce_pkg::*;

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int AW      = $clog2(CELLS);
  localparam int CW      = $clog2(COLUMNS);
  localparam int RW      = $clog2(ROWS);
  localparam int BOT_LIN = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_SCROLL,
    S_READ
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       cnt_q;
  logic [AW-1:0]       base_q;
  logic [AW-1:0]       lin_q;
  logic [CW-1:0]       col_q;
  logic [RW-1:0]       row_q;
  logic [ATTR_W-1:0]   attr_q;
  logic                done_q;
  logic [POS_W-1:0]    pos_q;
  logic [CHAR_W-1:0]   rchar_q;
  logic [ATTR_W-1:0]   rattr_q;

  logic                accept;
  cmd_e                cmd;
  logic                special;
  logic [2:0]          tab_step;
  logic [CW:0]         col_n;
  logic [RW:0]         row_n;
  logic [AW:0]         lin_n;
  logic [AW:0]         lin_nl;
  logic                scroll_n;
  logic [AW-1:0]       cur_phys;
  logic                rd_in_range;
  logic [AW-1:0]       rd_phys;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [CELL_W-1:0]   ram_rdata;

  function automatic logic [AW-1:0] to_phys(logic [AW-1:0] lin, logic [AW-1:0] base);
    logic [AW:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= (AW+1)'(CELLS)) begin
      sum = sum - (AW+1)'(CELLS);
    end
    return AW'(sum);
  endfunction

  assign accept   = start && !busy;
  assign cmd      = cmd_e'(cmd_i);
  assign busy     = (state_q != S_IDLE);
  assign special  = (char_code_i == CH_NEWLINE) || (char_code_i == CH_RETURN) ||
                    (char_code_i == CH_TAB);
  assign tab_step = TAB_STOP - {1'b0, col_q[1:0]};
  assign lin_nl   = {1'b0, lin_q} - (AW+1)'(col_q) + (AW+1)'(COLUMNS);
  assign cur_phys = to_phys(lin_q, base_q);

  assign rd_in_range = (32'(cell_index_i) < CELLS);
  assign rd_phys     = to_phys(AW'(cell_index_i), base_q);

  // next cursor for a put
  always_comb begin
    col_n    = {1'b0, col_q};
    row_n    = {1'b0, row_q};
    lin_n    = {1'b0, lin_q};
    scroll_n = 1'b0;
    if (char_code_i == CH_NEWLINE) begin
      col_n = '0;
      row_n = {1'b0, row_q} + 1'b1;
      lin_n = lin_nl;
    end else if (char_code_i == CH_RETURN) begin
      col_n = '0;
      lin_n = {1'b0, lin_q} - (AW+1)'(col_q);
    end else if (char_code_i == CH_TAB) begin
      col_n = {1'b0, col_q} + (CW+1)'(tab_step);
      lin_n = {1'b0, lin_q} + (AW+1)'(tab_step);
    end else begin
      col_n = {1'b0, col_q} + 1'b1;
      lin_n = {1'b0, lin_q} + 1'b1;
    end
    if (col_n >= (CW+1)'(COLUMNS)) begin
      col_n = '0;
      row_n = {1'b0, row_q} + 1'b1;
      lin_n = lin_nl;
    end
    if (row_n >= (RW+1)'(ROWS)) begin
      scroll_n = 1'b1;
      col_n    = '0;
      row_n    = (RW+1)'(ROWS - 1);
      lin_n    = (AW+1)'(BOT_LIN);
    end
  end

  // write port: sweeps own it, otherwise a printable put
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_phys;
    ram_wdata = {attr_q, char_code_i};
    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {ATTR_RESET, CH_SPACE};
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {attr_q, CH_SPACE};
      end
      S_SCROLL: begin
        ram_we    = 1'b1;
        ram_waddr = base_q + cnt_q;
        ram_wdata = {attr_q, CH_SPACE};
      end
      S_IDLE: begin
        ram_we = accept && (cmd == CMD_PUT) && !special;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_re = accept && (cmd == CMD_READ) && rd_in_range;

  tcce_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_phys),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      base_q  <= '0;
      lin_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      done_q  <= 1'b0;
      pos_q   <= '0;
      rchar_q <= '0;
      rattr_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(CELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rchar_q <= '0;
            rattr_q <= '0;
            cnt_q   <= '0;
            case (cmd)
              CMD_PUT: begin
                col_q <= CW'(col_n);
                row_q <= RW'(row_n);
                lin_q <= AW'(lin_n);
                pos_q <= POS_W'(lin_n);
                if (scroll_n) begin
                  state_q <= S_SCROLL;
                end else begin
                  done_q <= 1'b1;
                end
              end
              CMD_CLEAR: begin
                col_q   <= '0;
                row_q   <= '0;
                lin_q   <= '0;
                pos_q   <= '0;
                state_q <= S_CLEAR;
              end
              CMD_READ: begin
                pos_q <= POS_W'(lin_q);
                if (rd_in_range) begin
                  state_q <= S_READ;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: begin
                pos_q  <= POS_W'(lin_q);
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(CELLS - 1)) begin
            base_q  <= '0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_SCROLL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(COLUMNS - 1)) begin
            if ({1'b0, base_q} + (AW+1)'(COLUMNS) >= (AW+1)'(CELLS)) begin
              base_q <= '0;
            end else begin
              base_q <= base_q + AW'(COLUMNS);
            end
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          rchar_q <= ram_rdata[CHAR_W-1:0];
          rattr_q <= ram_rdata[CELL_W-1:CHAR_W];
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o       = done_q;
  assign cursor_pos_o = pos_q;
  assign cell_char_o  = rchar_q;
  assign cell_attr_o  = rattr_q;

endmodule

@@ sv/tcce_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ test/tb_text_console_cursor_engine.sv @@
// Self-checking testbench for the text console cursor engine.
`timescale 1ns / 100ps

module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int COLUMNS   = COLUMNS_DEF;
  localparam int ROWS      = ROWS_DEF;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int PHASE_OPS = 412;

  typedef struct {
    cmd_e              cmd;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } console_op_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } console_reply_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic [1:0]        cmd_i        = CMD_NONE;
  logic [CHAR_W-1:0] char_code_i  = '0;
  logic [IDX_W-1:0]  cell_index_i = '0;
  logic              done_o;
  logic [POS_W-1:0]  cursor_pos_o;
  logic [CHAR_W-1:0] cell_char_o;
  logic [ATTR_W-1:0] cell_attr_o;
  logic              cfg_we_i     = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata_i  = '0;

  text_console_cursor_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .done_o      (done_o),
    .cursor_pos_o(cursor_pos_o),
    .cell_char_o (cell_char_o),
    .cell_attr_o (cell_attr_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted screen and cursor
  logic [CELL_W-1:0] screen_mem [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] text_attr;

  console_op_t    console_op_q[$];
  console_reply_t reply_due_q[$];
  console_op_t    op_live;
  int             idle_pct      = 0;
  int             ops_queued    = 0;
  int             beats_checked = 0;
  int             mismatches    = 0;
  int             scrolls       = 0;
  int             clears        = 0;
  int             reads         = 0;
  int             attr_settings = 1;

  function automatic void wipe_screen();
    int i;
    for (i = 0; i < CELLS; i++) screen_mem[i] = {text_attr, CH_SPACE};
    cur_col = 0;
    cur_row = 0;
  endfunction

  function automatic console_reply_t console_apply(console_op_t op);
    console_reply_t r;
    int unsigned    pos;
    int             i;
    r.ch   = '0;
    r.attr = '0;
    case (op.cmd)
      CMD_PUT: begin
        if (op.ch == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (op.ch == CH_RETURN) begin
          cur_col = 0;
        end else if (op.ch == CH_TAB) begin
          cur_col += int'(TAB_STOP) - (cur_col % int'(TAB_STOP));
        end else begin
          screen_mem[cur_row * COLUMNS + cur_col] = {text_attr, op.ch};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = {text_attr, CH_SPACE};
          cur_row = ROWS - 1;
          cur_col = 0;
          scrolls++;
        end
      end
      CMD_CLEAR: begin
        wipe_screen();
        clears++;
      end
      CMD_READ: begin
        reads++;
        if (op.idx < CELLS) {r.attr, r.ch} = screen_mem[op.idx];
      end
      default: ;
    endcase
    pos   = cur_row * COLUMNS + cur_col;
    r.pos = pos[POS_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_op(cmd_e cmd, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
    console_op_t op;
    op.cmd = cmd;
    op.ch  = ch;
    op.idx = idx;
    console_op_q.push_back(op);
    ops_queued++;
  endtask

  task automatic push_read();
    if ($urandom_range(1) == 1) begin
      push_op(CMD_READ, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
    end else begin
      push_op(CMD_READ, CHAR_W'($urandom_range(255)),
              IDX_W'($urandom_range(CELLS - 1, CELLS - COLUMNS)));
    end
  endtask

  // one line of text with tabs, reads and unused commands mixed in
  task automatic queue_line();
    int n;
    int pick;
    int i;
    n = ($urandom_range(3) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 40);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_op(CMD_PUT, CH_TAB, IDX_W'($urandom_range(2047)));
      end else if (pick < 18) begin
        push_read();
      end else if (pick < 20) begin
        push_op(CMD_NONE, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
      end else begin
        push_op(CMD_PUT, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
      end
    end
    pick = $urandom_range(99);
    if (pick < 65) begin
      push_op(CMD_PUT, CH_NEWLINE, IDX_W'($urandom_range(2047)));
    end else if (pick < 80) begin
      push_op(CMD_PUT, CH_RETURN, IDX_W'($urandom_range(2047)));
    end
    if ($urandom_range(39) == 0) begin
      push_op(CMD_CLEAR, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
    end
    if ($urandom_range(14) == 0) begin
      repeat ($urandom_range(10, 30)) push_op(CMD_PUT, CH_NEWLINE, IDX_W'($urandom_range(2047)));
    end
  endtask

  task automatic settle();
    while (console_op_q.size() != 0 || start || reply_due_q.size() != 0 || busy) begin
      @(posedge clk_i);
    end
    repeat (COLUMNS + 4) @(posedge clk_i);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    text_attr    = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    attr_settings++;
  endtask

  task automatic run_phase(logic [ATTR_W-1:0] attr, int idle);
    int target;
    write_attr(attr);
    idle_pct = idle;
    target   = ops_queued + PHASE_OPS;
    while (ops_queued < target) queue_line();
    settle();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        reply_due_q.push_back(console_apply(op_live));
      end
      if (!(start && busy)) begin
        if (console_op_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          op_live       = console_op_q.pop_front();
          start        <= 1'b1;
          cmd_i        <= op_live.cmd;
          char_code_i  <= op_live.ch;
          cell_index_i <= op_live.idx;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    console_reply_t want;
    if (rst_ni && done_o) begin
      if (reply_due_q.size() == 0) begin
        report_mismatch("outstanding results", 0, 1);
      end else begin
        want = reply_due_q.pop_front();
        beats_checked++;
        if (cursor_pos_o !== want.pos) report_mismatch("cursor_pos", cursor_pos_o, want.pos);
        if (cell_char_o !== want.ch) report_mismatch("cell_char", cell_char_o, want.ch);
        if (cell_attr_o !== want.attr) report_mismatch("cell_attr", cell_attr_o, want.attr);
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("timeout: %0d results still outstanding", reply_due_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    text_attr = ATTR_RESET;
    wipe_screen();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    settle();

    push_op(CMD_PUT, 8'h00, 11'h7FF);
    push_op(CMD_PUT, 8'hFF, 11'h000);
    push_op(CMD_PUT, 8'h41, 11'h2AA);
    push_op(CMD_READ, 8'hFF, 11'd0);
    push_op(CMD_READ, 8'h00, 11'd1);
    push_op(CMD_READ, 8'h55, 11'd2);
    push_op(CMD_NONE, 8'h00, 11'd0);
    push_op(CMD_READ, 8'hAA, IDX_W'(CELLS - 1));
    push_op(CMD_READ, 8'h00, IDX_W'(CELLS));
    push_op(CMD_READ, 8'h00, 11'h7FF);
    push_op(CMD_PUT, CH_TAB, 11'h555);
    push_op(CMD_PUT, CH_TAB, 11'h2AA);
    push_op(CMD_PUT, 8'h7E, 11'h000);
    push_op(CMD_PUT, CH_RETURN, 11'h000);
    push_op(CMD_PUT, CH_NEWLINE, 11'h7FF);
    push_op(CMD_NONE, 8'hFF, 11'h7FF);
    push_op(CMD_NONE, 8'h00, 11'h000);
    push_op(CMD_CLEAR, 8'hFF, 11'h7FF);
    push_op(CMD_READ, 8'h00, 11'd0);
    push_op(CMD_PUT, CH_SPACE, 11'h000);
    settle();

    run_phase(8'h00, 0);
    run_phase(8'hFF, 84);
    run_phase(ATTR_W'($urandom_range(255)), 18);
    run_phase(ATTR_W'($urandom_range(255)), 0);
    repeat (8) @(posedge clk_i);

    $display("checked %0d result beats under %0d attribute settings", beats_checked,
             attr_settings);
    $display("  %0d scrolls, %0d clears, %0d cell reads", scrolls, clears, reads);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ text_console_cursor_engine.f @@
sv/tcce_pkg.sv
sv/tcce_ram.sv
sv/text_console_cursor_engine.sv
test/tb_text_console_cursor_engine.sv
